>>> hw/rtl/rof_pkg.sv
// ----------------------------------------------------------------------------
// rof_pkg: shared types and constants
// Field widths of the record channels, action codes and the walk token type.
// ----------------------------------------------------------------------------
package rof_pkg;

  localparam int IN_HANDLE_BITS  = 32;
  localparam int IN_SIZE_BITS    = 16;
  localparam int OFF_BITS        = 20;
  localparam int OUT_HANDLE_BITS = 32;
  localparam int OUT_OFF_BITS    = 16;

  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_FIND = 1'b1;

  // control part of the lookup token that walks the cell row
  typedef struct packed {
    logic valid;
    logic hit;
  } rof_tok_ctl_t;

endpackage

>>> hw/rtl/rof_ifs.sv
// ----------------------------------------------------------------------------
// rof channel interfaces
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface rof_in_if;
  import rof_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [IN_HANDLE_BITS-1:0] entry_handle;
  logic [IN_SIZE_BITS-1:0]   entry_size;
  logic [OFF_BITS-1:0]       text_pos;

  modport source (output valid, action, entry_handle, entry_size, text_pos,
                  input ready);
  modport sink   (input valid, action, entry_handle, entry_size, text_pos,
                  output ready);
endinterface

interface rof_out_if;
  import rof_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic                       evicted_valid;
  logic [OUT_HANDLE_BITS-1:0] result_handle;
  logic [OUT_OFF_BITS-1:0]    byte_offset;

  modport source (output valid, found, evicted_valid, result_handle, byte_offset,
                  input ready);
  modport sink   (input valid, found, evicted_valid, result_handle, byte_offset,
                  output ready);
endinterface

>>> hw/rtl/ring_entry_offset_finder_core.sv
// ----------------------------------------------------------------------------
// ring_entry_offset_finder_core: overwriting record ring with offset lookup
// Records sit in a row of cells ordered by age, newest in cell 0. An add
// shifts the row and returns the record pushed out of the last cell once the
// row is full. A find launches a token at the oldest end that steps one cell
// per clock toward the newest, subtracting record sizes until it lands.
// ----------------------------------------------------------------------------
// An add's result beat is registered and is shown in the cycle after the accept;
// the next beat is taken once that result is consumed. A find walks the lookup
// token one cell of the row per clock through all ENTRIES cells, then the result
// register is loaded; no new beat is taken during the walk.
// Results wait in an output register, so a new beat is taken in the cycle
// the previous result is consumed.
module ring_entry_offset_finder_core #(
  parameter int ENTRIES     = 16,
  parameter int HANDLE_BITS = 32,
  parameter int SIZE_BITS   = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  rof_in_if.sink   in_ch,
  rof_out_if.source out_ch
);
  import rof_pkg::*;

  localparam int REM_BITS = (OFF_BITS > SIZE_BITS) ? OFF_BITS : SIZE_BITS;

  logic                   cell_v [ENTRIES];
  logic [HANDLE_BITS-1:0] cell_h [ENTRIES];
  logic [SIZE_BITS-1:0]   cell_s [ENTRIES];

  rof_tok_ctl_t           tok_ctl_r [ENTRIES];
  logic [REM_BITS-1:0]    tok_rem_r [ENTRIES];
  logic [HANDLE_BITS-1:0] tok_hnd_r [ENTRIES];
  rof_tok_ctl_t           tok_ctl_o [ENTRIES];
  logic [REM_BITS-1:0]    tok_rem_o [ENTRIES];
  logic [HANDLE_BITS-1:0] tok_hnd_o [ENTRIES];

  logic                   busy_r;
  logic                   out_valid_r;
  logic                   found_r;
  logic                   evict_r;
  logic [OUT_HANDLE_BITS-1:0] hnd_r;
  logic [OUT_OFF_BITS-1:0]    off_r;

  logic in_ready;
  logic accept;
  logic do_add;
  logic do_find;
  logic walk_done;

  assign in_ready  = !busy_r && (!out_valid_r || out_ch.ready);
  assign accept    = in_ch.valid && in_ready;
  assign do_add    = accept && (in_ch.action == ACT_ADD);
  assign do_find   = accept && (in_ch.action == ACT_FIND);
  assign walk_done = tok_ctl_o[0].valid;

  genvar gi;
  generate
    for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
      logic                   pv;
      logic [HANDLE_BITS-1:0] ph;
      logic [SIZE_BITS-1:0]   ps;

      if (gi == 0) begin : g_head
        assign pv = 1'b1;
        assign ph = HANDLE_BITS'(in_ch.entry_handle);
        assign ps = SIZE_BITS'(in_ch.entry_size);
      end else begin : g_body
        assign pv = cell_v[gi-1];
        assign ph = cell_h[gi-1];
        assign ps = cell_s[gi-1];
      end

      rof_cell #(
        .HANDLE_BITS (HANDLE_BITS),
        .SIZE_BITS   (SIZE_BITS),
        .REM_BITS    (REM_BITS)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .shift_en    (do_add),
        .prev_v      (pv),
        .prev_h      (ph),
        .prev_s      (ps),
        .rec_v       (cell_v[gi]),
        .rec_h       (cell_h[gi]),
        .rec_s       (cell_s[gi]),
        .tok_ctl_in  (tok_ctl_r[gi]),
        .tok_rem_in  (tok_rem_r[gi]),
        .tok_hnd_in  (tok_hnd_r[gi]),
        .tok_ctl_out (tok_ctl_o[gi]),
        .tok_rem_out (tok_rem_o[gi]),
        .tok_hnd_out (tok_hnd_o[gi])
      );

      // token stage feeding this cell: launched at the oldest end, else
      // handed down from the older neighbor
      if (gi == ENTRIES-1) begin : g_launch
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            tok_ctl_r[gi] <= '0;
          end else begin
            tok_ctl_r[gi].valid <= do_find;
            tok_ctl_r[gi].hit   <= 1'b0;
          end
        end
        always_ff @(posedge clk) begin
          tok_rem_r[gi] <= REM_BITS'(in_ch.text_pos);
          tok_hnd_r[gi] <= '0;
        end
      end else begin : g_pass
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            tok_ctl_r[gi] <= '0;
          end else begin
            tok_ctl_r[gi] <= tok_ctl_o[gi+1];
          end
        end
        always_ff @(posedge clk) begin
          tok_rem_r[gi] <= tok_rem_o[gi+1];
          tok_hnd_r[gi] <= tok_hnd_o[gi+1];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (do_find) begin
        busy_r <= 1'b1;
      end else if (walk_done) begin
        busy_r <= 1'b0;
      end
      if (do_add || walk_done) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_add) begin
      // row full when the last cell holds a record; that record is pushed out
      found_r <= 1'b0;
      evict_r <= cell_v[ENTRIES-1];
      hnd_r   <= cell_v[ENTRIES-1] ? OUT_HANDLE_BITS'(cell_h[ENTRIES-1]) : '0;
      off_r   <= '0;
    end else if (walk_done) begin
      found_r <= tok_ctl_o[0].hit;
      evict_r <= 1'b0;
      hnd_r   <= tok_ctl_o[0].hit ? OUT_HANDLE_BITS'(tok_hnd_o[0]) : '0;
      off_r   <= tok_ctl_o[0].hit ? OUT_OFF_BITS'(tok_rem_o[0]) : '0;
    end
  end

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.found         = found_r;
  assign out_ch.evicted_valid = evict_r;
  assign out_ch.result_handle = hnd_r;
  assign out_ch.byte_offset   = off_r;

endmodule

>>> hw/rtl/rof_cell.sv
// ----------------------------------------------------------------------------
// rof_cell: one record slot of the age-ordered row
// Holds one record, shifts it to the older neighbor on an add, and applies
// one step of the offset walk to the token passing through.
// ----------------------------------------------------------------------------
module rof_cell #(
  parameter int HANDLE_BITS = 32,
  parameter int SIZE_BITS   = 16,
  parameter int REM_BITS    = 20
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   shift_en,
  input  logic                   prev_v,
  input  logic [HANDLE_BITS-1:0] prev_h,
  input  logic [SIZE_BITS-1:0]   prev_s,
  output logic                   rec_v,
  output logic [HANDLE_BITS-1:0] rec_h,
  output logic [SIZE_BITS-1:0]   rec_s,
  input  rof_pkg::rof_tok_ctl_t  tok_ctl_in,
  input  logic [REM_BITS-1:0]    tok_rem_in,
  input  logic [HANDLE_BITS-1:0] tok_hnd_in,
  output rof_pkg::rof_tok_ctl_t  tok_ctl_out,
  output logic [REM_BITS-1:0]    tok_rem_out,
  output logic [HANDLE_BITS-1:0] tok_hnd_out
);
  import rof_pkg::*;

  logic                   v_r;
  logic [HANDLE_BITS-1:0] h_r;
  logic [SIZE_BITS-1:0]   s_r;
  logic [REM_BITS-1:0]    size_ext;
  logic                   probe;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (shift_en) begin
      v_r <= prev_v;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      h_r <= prev_h;
      s_r <= prev_s;
    end
  end

  assign rec_v = v_r;
  assign rec_h = h_r;
  assign rec_s = s_r;

  assign size_ext = REM_BITS'(s_r);
  assign probe    = tok_ctl_in.valid && !tok_ctl_in.hit && v_r;

  always_comb begin
    tok_ctl_out = tok_ctl_in;
    tok_rem_out = tok_rem_in;
    tok_hnd_out = tok_hnd_in;
    if (probe) begin
      if (tok_rem_in < size_ext) begin
        // remaining offset stays as the byte offset inside this record
        tok_ctl_out.hit = 1'b1;
        tok_hnd_out     = h_r;
      end else begin
        tok_rem_out = tok_rem_in - size_ext;
      end
    end
  end

endmodule

>>> hw/rtl/rof_checker.sv
// ----------------------------------------------------------------------------
// rof_checker: port-level checks for the offset finder
// Result beat hold under stall and consistency of result fields.
// ----------------------------------------------------------------------------
module rof_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        found,
  input logic        evicted_valid,
  input logic [31:0] result_handle,
  input logic [15:0] byte_offset
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(found) &&
      $stable(evicted_valid) && $stable(result_handle) && $stable(byte_offset))
    else $error("result beat changed while stalled");

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(found && evicted_valid))
    else $error("beat marked both found and evicted");

  a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !found |-> byte_offset == 16'd0)
    else $error("byte offset set on a beat without a hit");

  a_handle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !found && !evicted_valid |-> result_handle == 32'd0)
    else $error("handle set on an empty result");

endmodule

bind ring_entry_offset_finder_core rof_checker u_rof_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .found         (out_ch.found),
  .evicted_valid (out_ch.evicted_valid),
  .result_handle (out_ch.result_handle),
  .byte_offset   (out_ch.byte_offset)
);
